// File: design/ipd_packet_parser_queue_assert.svh
// Assertion macros used by the checker module of the receive-frame parser.
// Every macro reports through $error with a fixed message.
`ifndef IPD_PACKET_PARSER_QUEUE_ASSERT_SVH
`define IPD_PACKET_PARSER_QUEUE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define IPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipd_packet_parser_queue: check failed");

// Next-cycle implication, off during reset.
`define IPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipd_packet_parser_queue: check failed");

// Next-cycle implication that also covers the reset cycles.
`define IPD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ipd_packet_parser_queue: check failed");

`endif

// File: design/ipd_pq_pkg.sv
package ipd_pq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int DATA_DEPTH_DEF  = 256;

    // Framing characters
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_COMMA = 8'h2C;
    localparam logic [7:0] C_COLON = 8'h3A;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [3:0] DEC_BASE = 4'd10;

    // Request codes
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_POP  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_DROP  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef enum logic [2:0] {
        PH_START,
        PH_FIND_ID,
        PH_ID,
        PH_SIZE,
        PH_DATA
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_RDATA,
        SQ_META,
        SQ_DONE
    } t_seq;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  queued_count;
        logic [15:0] head_conn_id;
        logic [15:0] head_size;
        logic [7:0]  head_header;
        logic [7:0]  head_byte;
    } t_rsp;

    typedef struct packed {
        logic [15:0] conn_id;
        logic [15:0] size;
        logic [7:0]  header;
    } t_meta;

    // Parser view of the byte being offered
    typedef struct packed {
        logic        data_en;   // byte is payload
        logic        done;      // byte completes the frame
        logic [15:0] pos;
        logic [15:0] conn_id;
        logic [15:0] size;
        logic [7:0]  header;
    } t_parse_evt;

    // acc*10 + (b - '0'), modulo 2^16
    function automatic logic [15:0] f_dec_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] prod;
        prod = acc * 16'(DEC_BASE);
        return prod + {8'h00, b} - {8'h00, C_ZERO};
    endfunction

endpackage

// File: design/ipd_pq_stream_if.sv
interface ipd_pq_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/ipd_pq_parser.sv
module ipd_pq_parser
    import ipd_pq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    output t_parse_evt o_evt
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_id, n_id;
    logic [15:0] r_size, n_size;
    logic [15:0] r_pos, n_pos;
    logic [7:0]  r_hdr, n_hdr;
    logic [15:0] limit;
    logic        last;

    assign limit = (r_size == 16'd0) ? 16'd1 : r_size;
    assign last  = ({1'b0, r_pos} + 17'd1) >= {1'b0, limit};

    // next state
    always_comb begin
        n_phase = r_phase;
        n_id    = r_id;
        n_size  = r_size;
        n_pos   = r_pos;
        n_hdr   = r_hdr;
        if (i_en) begin
            unique case (r_phase)
                PH_FIND_ID: begin
                    if (i_byte == C_COMMA) begin
                        n_phase = PH_ID;
                        n_id    = 16'd0;
                    end
                end
                PH_ID: begin
                    if (i_byte == C_COMMA) begin
                        n_phase = PH_SIZE;
                        n_size  = 16'd0;
                    end else begin
                        n_id = f_dec_step(r_id, i_byte);
                    end
                end
                PH_SIZE: begin
                    if (i_byte == C_COLON) begin
                        n_phase = PH_DATA;
                        n_pos   = 16'd0;
                    end else begin
                        n_size = f_dec_step(r_size, i_byte);
                    end
                end
                PH_DATA: begin
                    n_pos = r_pos + 16'd1;
                    if (r_pos == 16'd0) begin
                        n_hdr = i_byte;
                    end
                    if (last) begin
                        n_phase = PH_START;
                    end
                end
                default: begin
                    n_phase = (i_byte == C_PLUS) ? PH_FIND_ID : PH_START;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        o_evt.data_en = (r_phase == PH_DATA);
        o_evt.done    = (r_phase == PH_DATA) && last;
        o_evt.pos     = r_pos;
        o_evt.conn_id = r_id;
        o_evt.size    = r_size;
        o_evt.header  = (r_pos == 16'd0) ? i_byte : r_hdr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_id    <= 16'd0;
            r_size  <= 16'd0;
            r_pos   <= 16'd0;
        end else begin
            r_phase <= n_phase;
            r_id    <= n_id;
            r_size  <= n_size;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

endmodule

// File: design/ipd_packet_parser_queue.sv
// Receive-frame parser with a packet queue.
//
// Channels: i_req (sink) carries one request per transaction: a serial byte,
// a read of one payload byte of the head packet, or a pop of the head packet.
// o_rsp (source) returns exactly one result transaction per request, in order,
// with the status, the packet count and the head packet's fields.
//
// Timing: a request is taken only while the sequencer is idle. A byte, a pop
// that leaves the queue empty or a short read misses the memories and goes
// straight to SQ_DONE, which loads its result into the o_rsp register; a read
// that hits the payload memory, a pop with packets left, or a byte that drops
// the oldest packet first passes through SQ_RDATA or SQ_META for the registered
// memory read. The next request is taken in the cycle after the result is
// loaded, so a new request is not taken while the last one is still in work.
//
// Reset (i_rst_n low at a clock edge) empties the queue and puts the parser
// back to hunting for '+'. The memories are not cleared; a slot is read only
// after it was written. A stalled o_rsp keeps its result in the output register;
// one more request is still accepted and worked, then waits for the register.
module ipd_packet_parser_queue
    import ipd_pq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int DATA_DEPTH  = DATA_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ipd_pq_stream_if.sink   i_req,
    ipd_pq_stream_if.source o_rsp
);

    // One spare slot so the frame in flight never overwrites a queued packet
    localparam int SLOTS     = QUEUE_DEPTH + 1;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_W     = $clog2(DATA_DEPTH);
    localparam int PAY_DEPTH = SLOTS * DATA_DEPTH;
    localparam int PAY_AW    = $clog2(PAY_DEPTH);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
    localparam logic [PAY_AW-1:0] ROW_SPAN  = PAY_AW'(DATA_DEPTH);
    localparam logic [15:0]       DD_16     = 16'(DATA_DEPTH);

    // Sequencer and queue control
    t_seq              r_seq, n_seq;
    logic [SLOT_W-1:0] r_head_ptr, n_head_ptr;
    logic [SLOT_W-1:0] r_tail_ptr, n_tail_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid, n_out_valid;

    // Result under construction and cached head slot
    logic [1:0]  r_status, n_status;
    logic [7:0]  r_hbyte, n_hbyte;
    t_meta       r_head, n_head;
    t_rsp        r_out, n_out;

    // Memories
    logic [7:0]  r_pay_mem [PAY_DEPTH];
    t_meta       r_meta_mem [SLOTS];
    logic [7:0]  r_pay_q;
    t_meta       r_meta_q;

    logic              pay_we;
    logic [PAY_AW-1:0] pay_wa;
    logic [PAY_AW-1:0] pay_ra;
    logic              meta_we;
    logic [SLOT_W-1:0] meta_ra;

    // Decoded request
    t_parse_evt        evt;
    logic              in_fire;
    logic              byte_fire;
    logic [1:0]        req;
    logic [7:0]        idx;
    logic              q_empty;
    logic              q_full;
    logic              rd_hit;
    logic              out_free;
    logic [SLOT_W-1:0] head_nxt;
    logic [SLOT_W-1:0] tail_nxt;
    logic [PAY_AW-1:0] head_base;
    logic [PAY_AW-1:0] tail_base;

    assign req       = i_req.data.req_type;
    assign idx       = i_req.data.read_index;
    assign in_fire   = i_req.valid && i_req.ready;
    assign byte_fire = in_fire && (req == REQ_BYTE);
    assign q_empty   = (r_count == '0);
    assign q_full    = (r_count == CNT_FULL);
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign head_nxt  = (r_head_ptr == SLOT_LAST) ? '0 : r_head_ptr + 1'b1;
    assign tail_nxt  = (r_tail_ptr == SLOT_LAST) ? '0 : r_tail_ptr + 1'b1;
    assign head_base = PAY_AW'(r_head_ptr) * ROW_SPAN;
    assign tail_base = PAY_AW'(r_tail_ptr) * ROW_SPAN;

    // Index inside min(max(size,1), DATA_DEPTH) of the head packet
    assign rd_hit = ({8'h00, idx} < DD_16)
                  && ((idx == 8'd0) || ({8'h00, idx} < r_head.size));

    ipd_pq_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (byte_fire),
        .i_byte  (i_req.data.rx_byte),
        .o_evt   (evt)
    );

    // Sequencer next state
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SQ_IDLE: begin
                if (in_fire) begin
                    priority case (req)
                        REQ_BYTE: n_seq = (evt.done && q_full) ? SQ_META : SQ_DONE;
                        REQ_READ: n_seq = (!q_empty && rd_hit) ? SQ_RDATA : SQ_DONE;
                        REQ_POP:  n_seq = (!q_empty && (r_count != CNT_ONE)) ? SQ_META
                                                                             : SQ_DONE;
                        default:  n_seq = SQ_DONE;
                    endcase
                end
            end
            SQ_RDATA: n_seq = SQ_DONE;
            SQ_META:  n_seq = SQ_DONE;
            SQ_DONE:  n_seq = out_free ? SQ_IDLE : SQ_DONE;
        endcase
    end

    // Datapath control
    always_comb begin
        i_req.ready = (r_seq == SQ_IDLE);
        n_head_ptr  = r_head_ptr;
        n_tail_ptr  = r_tail_ptr;
        n_count     = r_count;
        n_status    = r_status;
        n_hbyte     = r_hbyte;
        n_head      = r_head;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        pay_we      = 1'b0;
        pay_wa      = tail_base + PAY_AW'(evt.pos[POS_W-1:0]);
        pay_ra      = head_base + PAY_AW'(idx);
        meta_we     = 1'b0;
        meta_ra     = head_nxt;

        unique case (r_seq)
            SQ_IDLE: begin
                if (in_fire) begin
                    n_status = ST_OK;
                    n_hbyte  = 8'd0;
                    priority case (req)
                        REQ_BYTE: begin
                            // payload beyond DATA_DEPTH counts but is not kept
                            pay_we = evt.data_en && (evt.pos < DD_16);
                            if (evt.done) begin
                                meta_we    = 1'b1;
                                n_tail_ptr = tail_nxt;
                                if (q_full) begin
                                    n_head_ptr = head_nxt;
                                    n_status   = ST_DROP;
                                end else begin
                                    n_count  = r_count + 1'b1;
                                    n_status = ST_DONE;
                                    if (q_empty) begin
                                        n_head.conn_id = evt.conn_id;
                                        n_head.size    = evt.size;
                                        n_head.header  = evt.header;
                                    end
                                end
                            end
                        end
                        REQ_READ: begin
                            if (q_empty) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        REQ_POP: begin
                            if (q_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_head_ptr = head_nxt;
                                n_count    = r_count - 1'b1;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            SQ_RDATA: begin
                n_hbyte = r_pay_q;
            end
            SQ_META: begin
                n_head = r_meta_q;
            end
            SQ_DONE: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = r_status;
                    n_out.queued_count = 4'(r_count);
                    n_out.head_byte    = r_hbyte;
                    if (q_empty) begin
                        n_out.head_conn_id = 16'd0;
                        n_out.head_size    = 16'd0;
                        n_out.head_header  = 8'd0;
                    end else begin
                        n_out.head_conn_id = r_head.conn_id;
                        n_out.head_size    = r_head.size;
                        n_out.head_header  = r_head.header;
                    end
                end
            end
        endcase
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_IDLE;
            r_head_ptr  <= '0;
            r_tail_ptr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_head_ptr  <= n_head_ptr;
            r_tail_ptr  <= n_tail_ptr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_hbyte  <= n_hbyte;
        r_head   <= n_head;
        r_out    <= n_out;
    end

    // Payload memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (pay_we) begin
            r_pay_mem[pay_wa] <= i_req.data.rx_byte;
        end
        r_pay_q <= r_pay_mem[pay_ra];
    end

    // Slot memory: written at the tail on completion, read at the next head.
    // The two addresses differ whenever both are active (queue depth >= 2).
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[r_tail_ptr] <= '{conn_id: evt.conn_id, size: evt.size,
                                        header: evt.header};
        end
        r_meta_q <= r_meta_mem[meta_ra];
    end

endmodule

// File: design/ipd_pq_checker.sv
`include "ipd_packet_parser_queue_assert.svh"

module ipd_pq_checker
    import ipd_pq_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp
);

    `IPD_ASSERT_NEXT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n, !i_rsp_valid)
    `IPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp))
    `IPD_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, i_rsp_valid && (i_rsp.status == ST_EMPTY), (i_rsp.queued_count == 4'd0) && (i_rsp.head_conn_id == 16'd0) && (i_rsp.head_size == 16'd0) && (i_rsp.head_header == 8'd0) && (i_rsp.head_byte == 8'd0))
    `IPD_ASSERT_NOW(a_done_no_byte, i_clk, i_rst_n, i_rsp_valid && ((i_rsp.status == ST_DONE) || (i_rsp.status == ST_DROP)), i_rsp.head_byte == 8'd0)

endmodule

bind ipd_packet_parser_queue ipd_pq_checker u_ipd_pq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.data)
);

// File: tb/ipd_packet_parser_queue_tb.sv
module ipd_packet_parser_queue_tb;
    import ipd_pq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QD = QUEUE_DEPTH_DEF;
    localparam int DD = DATA_DEPTH_DEF;
    localparam int SLOTS = QD + 1;          // spare slot holds the frame in progress
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1500;
    localparam int QUIET_LIMIT = 2000;      // cycles with no transaction on either channel
    localparam int HOLD_CYCLES = 400;       // long receiver hold-off
    localparam int MAX_PRINTS = 40;

    logic i_clk;
    logic i_rst_n;

    ipd_pq_stream_if #(.t_payload(t_req)) req_if ();
    ipd_pq_stream_if #(.t_payload(t_rsp)) rsp_if ();

    ipd_packet_parser_queue #(
        .QUEUE_DEPTH(QD),
        .DATA_DEPTH (DD)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    // ------------------------------------------------------------------
    // Frame parser / packet queue predictor
    // ------------------------------------------------------------------
    t_phase      fp_phase;
    logic [15:0] fp_id;
    logic [15:0] fp_size;
    logic [15:0] fp_pos;
    logic [7:0]  pq_data [SLOTS][DD];
    logic [15:0] pq_id [SLOTS];
    logic [15:0] pq_size [SLOTS];
    logic [7:0]  pq_hdr [SLOTS];
    int          pq_head;
    int          pq_tail;
    int          pq_count;

    t_rsp rsp_expect_q[$];

    // Knobs shared between the sequence tasks and the handshake processes
    bit req_gaps;
    bit rsp_stalls;
    int hold_req;

    int err_cnt;
    int n_sent;
    int n_noise;
    int quiet_cycles;

    // Decimal accumulate, modulo 2^16; non-digits contribute byte - '0'
    function automatic logic [15:0] dec_next(input logic [15:0] acc, input logic [7:0] b);
        return 16'(acc * 16'd10 + {8'h00, b} - {8'h00, C_ZERO});
    endfunction

    // Applies one request to the predictor state and returns the expected result
    function automatic t_rsp frame_step(input t_req r);
        t_rsp o;
        int   lim;
        int   p;
        o = '0;
        o.status = ST_OK;
        case (r.req_type)
            REQ_BYTE: begin
                case (fp_phase)
                    PH_FIND_ID: begin
                        if (r.rx_byte == C_COMMA) begin
                            fp_phase = PH_ID;
                            fp_id = '0;
                        end
                    end
                    PH_ID: begin
                        if (r.rx_byte == C_COMMA) begin
                            fp_phase = PH_SIZE;
                            fp_size = '0;
                        end else begin
                            fp_id = dec_next(fp_id, r.rx_byte);
                        end
                    end
                    PH_SIZE: begin
                        if (r.rx_byte == C_COLON) begin
                            fp_phase = PH_DATA;
                            fp_pos = '0;
                        end else begin
                            fp_size = dec_next(fp_size, r.rx_byte);
                        end
                    end
                    PH_DATA: begin
                        p = fp_pos;
                        lim = (fp_size != 0) ? int'(fp_size) : 1;
                        // bytes past the store are counted, not kept
                        if (p < DD) pq_data[pq_tail][p] = r.rx_byte;
                        if (p == 0) pq_hdr[pq_tail] = r.rx_byte;
                        p++;
                        fp_pos = 16'(p);
                        if (p >= lim) begin
                            pq_id[pq_tail] = fp_id;
                            pq_size[pq_tail] = fp_size;
                            pq_tail = (pq_tail + 1) % SLOTS;
                            if (pq_count >= QD) begin
                                // full: oldest packet falls out
                                pq_head = (pq_head + 1) % SLOTS;
                                o.status = ST_DROP;
                            end else begin
                                pq_count++;
                                o.status = ST_DONE;
                            end
                            fp_phase = PH_START;
                        end
                    end
                    default: begin
                        fp_phase = (r.rx_byte == C_PLUS) ? PH_FIND_ID : PH_START;
                    end
                endcase
            end
            REQ_READ: begin
                if (pq_count == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    lim = (pq_size[pq_head] != 0) ? int'(pq_size[pq_head]) : 1;
                    if (lim > DD) lim = DD;
                    if (int'(r.read_index) < lim) o.head_byte = pq_data[pq_head][r.read_index];
                end
            end
            REQ_POP: begin
                if (pq_count == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    pq_head = (pq_head + 1) % SLOTS;
                    pq_count--;
                end
            end
            default: ;
        endcase
        o.queued_count = 4'(pq_count);
        if (pq_count != 0) begin
            o.head_conn_id = pq_id[pq_head];
            o.head_size = pq_size[pq_head];
            o.head_header = pq_hdr[pq_head];
        end
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Clock, mismatch reporting
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_err(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) report_err($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Request side: one transaction per call, prediction taken at acceptance
    // ------------------------------------------------------------------
    task automatic send_req(input logic [1:0] rt, input logic [7:0] b, input logic [7:0] idx);
        t_req r;
        r.req_type = rt;
        r.rx_byte = b;
        r.read_index = idx;
        while (req_gaps && $urandom_range(99) < 9) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.data = r;
        do @(posedge i_clk); while (!req_if.ready);
        rsp_expect_q.push_back(frame_step(r));
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_char(input logic [7:0] b);
        send_req(REQ_BYTE, b, 8'($urandom_range(255)));
    endtask

    task automatic read_byte(input logic [7:0] idx);
        send_req(REQ_READ, 8'($urandom_range(255)), idx);
    endtask

    task automatic pop_head();
        send_req(REQ_POP, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    // A read or pop slipped in between serial bytes; must not disturb the parse
    task automatic side_req(input bit mix);
        if (mix && $urandom_range(99) < 5) begin
            if ($urandom_range(1) != 0) read_byte(8'($urandom_range(15)));
            else pop_head();
        end
    endtask

    task automatic send_text(input string s, input bit mix);
        foreach (s[i]) begin
            side_req(mix);
            send_char(s[i]);
        end
    endtask

    // Well-formed frame with random payload
    task automatic send_frame(input int unsigned id, input int unsigned size, input bit mix);
        int unsigned n;
        send_text($sformatf("+IPD,%0d,%0d:", id, size), mix);
        n = (size == 0) ? 1 : size;
        repeat (n) begin
            side_req(mix);
            send_char(8'($urandom_range(255)));
        end
    endtask

    task automatic drain_queue();
        while (pq_count > 0) pop_head();
        pop_head();     // one more on empty
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pattern and the scoreboard check
    // ------------------------------------------------------------------
    initial begin : rsp_ready_gen
        int n;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                // long hold-off, counted here
                n = hold_req;
                hold_req = 0;
                rsp_if.ready = 1'b0;
                repeat (n) @(negedge i_clk);
            end
            rsp_if.ready = !(rsp_stalls && $urandom_range(99) < 9);
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_rsp got;
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (rsp_expect_q.size() == 0) begin
                report_err($sformatf("result with nothing expected: 0x%0h", got));
            end else begin
                want = rsp_expect_q.pop_front();
                check_field("status", got.status, want.status);
                check_field("queued_count", got.queued_count, want.queued_count);
                check_field("head_conn_id", got.head_conn_id, want.head_conn_id);
                check_field("head_size", got.head_size, want.head_size);
                check_field("head_header", got.head_header, want.head_header);
                check_field("head_byte", got.head_byte, want.head_byte);
            end
        end
    end

    // Watchdog: gives up when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Read/pop with nothing queued, plus the unused request code
    task automatic test_empty_queue();
        read_byte(8'd0);
        read_byte(8'hFF);
        pop_head();
        send_req(REQ_UNUSED, 8'hFF, 8'hFF);
    endtask

    // Short frame with '+' inside the payload; read within and past the data
    task automatic test_frame_basic();
        send_text("+,7,2:+k", 1'b0);
        read_byte(8'd0);
        read_byte(8'd1);
        read_byte(8'd2);
        read_byte(8'hFF);
        pop_head();
    endtask

    // Non-digit in the id, size that wraps to zero (one payload byte),
    // unused request code mid-frame
    task automatic test_field_edges();
        send_text("+,9x,65", 1'b0);
        send_req(REQ_UNUSED, 8'h00, 8'h00);
        send_text("536:", 1'b0);
        send_char(8'hFF);
        read_byte(8'd0);
        pop_head();
    endtask

    // Payload longer than the per-slot store: tail bytes counted only
    task automatic test_long_payload();
        send_frame(65535, 300, 1'b0);
        read_byte(8'd0);
        read_byte(8'd200);
        read_byte(8'hFF);
        pop_head();
    endtask

    // Fill past QUEUE_DEPTH so the oldest packets drop, then empty it
    task automatic test_queue_overflow();
        for (int i = 0; i < QD + 3; i++) send_frame(i * 111, $urandom_range(3), 1'b0);
        read_byte(8'd0);
        drain_queue();
    endtask

    // Receiver holds off while frames keep coming: the block must stall its input
    task automatic test_backpressure();
        hold_req = HOLD_CYCLES;
        repeat (4) send_frame($urandom_range(65535), $urandom_range(1, 6), 1'b1);
        drain_queue();
    endtask

    // Mostly well-formed frames with random content, mixed with reads/pops,
    // truncated headers, junk in the id and idle-line noise
    task automatic test_random();
        int sel;
        int base;
        logic [7:0] junk;
        base = n_sent - n_noise;
        while (n_sent - n_noise < RANDOM_ITEMS) begin
            // long stretch first with no idling on either side
            if (n_sent - n_noise - base > RANDOM_ITEMS / 3) begin
                req_gaps = 1'b1;
                rsp_stalls = 1'b1;
            end
            sel = $urandom_range(99);
            if (sel < 55) begin
                send_frame($urandom_range(65535),
                           ($urandom_range(39) == 0) ? $urandom_range(300) : $urandom_range(12),
                           1'b1);
            end else if (sel < 80) begin
                repeat ($urandom_range(3)) begin
                    if ($urandom_range(2) == 0) pop_head();
                    else read_byte(($urandom_range(1) != 0) ? 8'($urandom_range(15))
                                                             : 8'($urandom_range(255)));
                end
            end else if (sel < 86) begin
                // truncated before the id field; next '+' is ignored until ','
                send_text("+IP", 1'b0);
            end else if (sel < 91) begin
                // junk character inside the id, then a normal tail
                do junk = 8'($urandom_range(255)); while (junk == C_COMMA);
                send_text("+IPD,1", 1'b1);
                send_char(junk);
                send_text($sformatf(",%0d:", $urandom_range(4)), 1'b1);
                repeat (5) begin
                    if (fp_phase == PH_DATA) send_char(8'($urandom_range(255)));
                end
            end else if (sel < 96) begin
                // line noise while hunting for a frame start
                if (fp_phase == PH_START) begin
                    repeat ($urandom_range(1, 4)) begin
                        do junk = 8'($urandom_range(255)); while (junk == C_PLUS);
                        send_char(junk);
                        n_noise++;
                    end
                end
            end else if (sel < 98) begin
                send_req(REQ_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end else begin
                drain_queue();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        fp_phase = PH_START;
        fp_id = '0;
        fp_size = '0;
        fp_pos = '0;
        pq_head = 0;
        pq_tail = 0;
        pq_count = 0;
        err_cnt = 0;
        n_sent = 0;
        n_noise = 0;
        quiet_cycles = 0;
        hold_req = 0;
        req_gaps = 1'b1;
        rsp_stalls = 1'b1;
        req_if.valid = 1'b0;
        req_if.data = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_queue();
        test_frame_basic();
        test_field_edges();
        test_long_payload();
        test_queue_overflow();
        test_backpressure();
        req_gaps = 1'b0;
        rsp_stalls = 1'b0;
        test_random();

        // let the pipeline empty; the watchdog bounds this wait
        req_if.valid = 1'b0;
        rsp_stalls = 1'b0;
        wait (rsp_expect_q.size() == 0);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
